// ===== rtl/icfd_pkg.sv =====
// ----------------------------------------------------------------------------
// icfd_pkg
// Shared types and constants of the interlaced CCD field demultiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package icfd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_W      = 13;
    localparam int OFFSET_W   = 8;
    localparam int SHIFT_W    = 4;
    localparam int VALUE_W    = 16;
    localparam int SXY_W      = 6;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BINNED_MODE   = 3'd0,
        CFG_SAMPLE_OFFSET = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_IMAGE_HEIGHT  = 3'd3,
        CFG_GREEN_DX      = 3'd4,
        CFG_GREEN_DY      = 3'd5,
        CFG_RED_DX        = 3'd6,
        CFG_RED_DY        = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/icfd_out_buf.sv =====
// ----------------------------------------------------------------------------
// icfd_out_buf
// Two-entry output buffer: result register plus skid entry, so the producer
// sees a registered full flag and never a combinational stall path.
// ----------------------------------------------------------------------------
`default_nettype none

module icfd_out_buf
    import icfd_pkg::*;
#(
    parameter int DATA_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_stall
);

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic              r_skid_valid, n_skid_valid;
    logic [DATA_W-1:0] r_skid_data, n_skid_data;
    logic              take;

    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || take) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/interlaced_ccd_field_demux.sv =====
// ----------------------------------------------------------------------------
// interlaced_ccd_field_demux
// Maps interlaced CCD field samples in readout order to image pixel positions.
// ----------------------------------------------------------------------------
// One sample is taken every clock while the input is not stalled. The sample
// counter, the per-pass tile counters and the pixel position are all worked
// out in the cycle a sample is accepted; counters and result are registered
// at the accepting edge into the output buffer. A two-entry output buffer
// keeps input acceptance going while one result waits; input stalls only
// when both entries are occupied. Samples that fall outside the image, before
// the start offset or past the tile count give no result. Configuration must
// be written only while the block is idle; the block does not enforce this.
`default_nettype none

module interlaced_ccd_field_demux
    import icfd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PXW        = $clog2(MAX_WIDTH),
    parameter int PYW        = $clog2(MAX_HEIGHT)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_field_select,
    input  wire logic                  i_first_sample,
    input  wire logic [VALUE_W-1:0]    i_sample_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [PXW-1:0]             o_pixel_x,
    output logic [PYW-1:0]             o_pixel_y,
    output logic [VALUE_W-1:0]         o_pixel_value,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LIMIT  = MAX_WIDTH * MAX_HEIGHT / 2;
    localparam int SW     = $clog2(LIMIT);
    localparam int CMPW   = (SW > 10) ? SW : 10;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int CWW    = (WW > DIM_W) ? WW : DIM_W;
    localparam int CHW    = (HW > DIM_W) ? HW : DIM_W;
    localparam int MAX_NX = (MAX_WIDTH + 3) / 4;
    localparam int MAX_NY = (MAX_HEIGHT + 3) / 4;
    localparam int NXW    = $clog2(MAX_NX + 1);
    localparam int NYW    = $clog2(MAX_NY + 1);
    localparam int XW     = WW + 3;
    localparam int YW     = HW + 3;
    localparam int DW     = PXW + PYW + VALUE_W;

    // configuration
    logic                      r_binned;
    logic [OFFSET_W-1:0]       r_offset;
    logic [DIM_W-1:0]          r_width, r_height;
    logic signed [SHIFT_W-1:0] r_green_dx, r_green_dy, r_red_dx, r_red_dy;

    // field state
    logic [SW-1:0]  r_sample_index, n_sample_index;
    logic [NXW-1:0] r_fwd_col, n_fwd_col, r_mir_col, n_mir_col;
    logic [NYW-1:0] r_fwd_row, n_fwd_row, r_mir_row, n_mir_row;
    logic           r_fwd_done, n_fwd_done, r_mir_done, n_mir_done;
    logic           r_past_end, n_past_end;

    logic                  acc, live, res_valid, buf_full;
    logic [SW-1:0]         s_cur;
    logic [WW-1:0]         w;
    logic [HW-1:0]         h;
    logic [NXW-1:0]        nx;
    logic [NYW-1:0]        ny;
    logic [9:0]            bf, bm;
    logic                  fwd_hit, mir_hit;
    logic [1:0]            k, j;
    logic [NXW-1:0]        col_sel;
    logic [NYW-1:0]        row_sel;
    logic                  done_sel, blocked;
    logic signed [SXY_W-1:0] sx, sy;
    logic signed [XW-1:0]  x_pos, x_fin;
    logic signed [YW-1:0]  y_pos;
    logic [DW-1:0]         res_data, buf_data;

    assign acc         = i_valid && !o_stall;
    assign o_stall     = buf_full;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w = (CWW'(r_width) > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_width);
        h = (CHW'(r_height) > CHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(r_height);
        nx = NXW'(((WW + 1)'(w) + (WW + 1)'(3)) >> 2);
        ny = NYW'(((HW + 1)'(h) + (HW + 1)'(3)) >> 2);
        bm = {1'b0, r_offset, 1'b1};
        bf = r_binned ? {1'b0, r_offset, 1'b0} : ({1'b0, r_offset, 1'b0} + 10'd2);
    end

    always_comb begin
        n_sample_index = r_sample_index;
        n_fwd_col  = r_fwd_col;
        n_fwd_row  = r_fwd_row;
        n_mir_col  = r_mir_col;
        n_mir_row  = r_mir_row;
        n_fwd_done = r_fwd_done;
        n_mir_done = r_mir_done;
        n_past_end = r_past_end;
        live       = acc && (i_first_sample || !r_past_end);
        s_cur      = i_first_sample ? '0 : r_sample_index;
        fwd_hit    = 1'b0;
        mir_hit    = 1'b0;
        k          = 2'd0;
        j          = 2'd0;
        col_sel    = '0;
        row_sel    = '0;
        done_sel   = 1'b0;
        blocked    = 1'b1;
        sx         = '0;
        sy         = '0;
        x_pos      = '0;
        x_fin      = '0;
        y_pos      = '0;
        res_valid  = 1'b0;

        if (acc && i_first_sample) begin
            n_past_end = 1'b0;
            n_fwd_col  = '0;
            n_fwd_row  = '0;
            n_mir_col  = '0;
            n_mir_row  = '0;
            n_fwd_done = 1'b0;
            n_mir_done = 1'b0;
        end

        if (live) begin
            if ((SW + 1)'(s_cur) + (SW + 1)'(1) >= (SW + 1)'(LIMIT)) begin
                n_past_end = 1'b1;
            end else begin
                n_sample_index = s_cur + SW'(1);
            end

            fwd_hit = (CMPW'(s_cur) >= CMPW'(bf)) && !s_cur[0];
            mir_hit = !fwd_hit && (CMPW'(s_cur) >= CMPW'(bm)) && s_cur[0];

            if (fwd_hit) begin
                k        = s_cur[2:1] - bf[2:1];
                j        = r_binned ? (k ^ 2'd1) : k;
                col_sel  = n_fwd_col;
                row_sel  = n_fwd_row;
                done_sel = n_fwd_done;
            end else begin
                k        = s_cur[2:1] - bm[2:1];
                j        = k;
                col_sel  = n_mir_col;
                row_sel  = n_mir_row;
                done_sel = n_mir_done;
            end

            blocked = done_sel || (w == '0) || (h == '0) || (col_sel >= nx);

            if (r_binned) begin
                if (fwd_hit) begin
                    sx = i_field_select ? (SXY_W'(r_green_dx) + SXY_W'(2)) : SXY_W'(1);
                    sy = i_field_select ? (SXY_W'(r_green_dy) + SXY_W'(1)) : SXY_W'(0);
                end else begin
                    sx = i_field_select ? (SXY_W'(r_red_dx) - SXY_W'(2)) : -SXY_W'(1);
                    sy = i_field_select ? SXY_W'(r_red_dy) : SXY_W'(1);
                end
            end else begin
                if (fwd_hit) begin
                    sx = i_field_select ? SXY_W'(1) : SXY_W'(2);
                    sy = i_field_select ? SXY_W'(0) : -SXY_W'(1);
                end else begin
                    sx = i_field_select ? SXY_W'(0) : SXY_W'(1);
                    sy = i_field_select ? SXY_W'(0) : SXY_W'(1);
                end
            end

            x_pos = signed'(XW'({col_sel, j[0], 1'b0})) + XW'(sx);
            y_pos = signed'(YW'({row_sel, j[1], 1'b0})) + YW'(sy);
            x_fin = fwd_hit ? x_pos : (signed'(XW'(w)) - x_pos);

            if (fwd_hit || mir_hit) begin
                if (blocked) begin
                    if (fwd_hit) begin
                        n_fwd_done = 1'b1;
                    end else begin
                        n_mir_done = 1'b1;
                    end
                end else begin
                    if (k == 2'd3) begin
                        if (row_sel + NYW'(1) >= ny) begin
                            if (fwd_hit) begin
                                n_fwd_row = '0;
                                n_fwd_col = col_sel + NXW'(1);
                                n_fwd_done = (col_sel + NXW'(1) >= nx);
                            end else begin
                                n_mir_row = '0;
                                n_mir_col = col_sel + NXW'(1);
                                n_mir_done = (col_sel + NXW'(1) >= nx);
                            end
                        end else if (fwd_hit) begin
                            n_fwd_row = row_sel + NYW'(1);
                        end else begin
                            n_mir_row = row_sel + NYW'(1);
                        end
                    end
                    res_valid = !x_fin[XW-1] && (x_fin < signed'(XW'(w)))
                             && !y_pos[YW-1] && (y_pos < signed'(YW'(h)));
                end
            end
        end
    end

    assign res_data = {x_fin[PXW-1:0], y_pos[PYW-1:0], i_sample_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binned   <= 1'b0;
            r_offset   <= '0;
            r_width    <= DIM_RESET;
            r_height   <= DIM_RESET;
            r_green_dx <= '0;
            r_green_dy <= '0;
            r_red_dx   <= '0;
            r_red_dy   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BINNED_MODE:   r_binned   <= i_cfg_data[0];
                CFG_SAMPLE_OFFSET: r_offset   <= i_cfg_data[OFFSET_W-1:0];
                CFG_IMAGE_WIDTH:   r_width    <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_height   <= i_cfg_data[DIM_W-1:0];
                CFG_GREEN_DX:      r_green_dx <= i_cfg_data[SHIFT_W-1:0];
                CFG_GREEN_DY:      r_green_dy <= i_cfg_data[SHIFT_W-1:0];
                CFG_RED_DX:        r_red_dx   <= i_cfg_data[SHIFT_W-1:0];
                CFG_RED_DY:        r_red_dy   <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_fwd_col      <= '0;
            r_fwd_row      <= '0;
            r_mir_col      <= '0;
            r_mir_row      <= '0;
            r_fwd_done     <= 1'b0;
            r_mir_done     <= 1'b0;
            r_past_end     <= 1'b0;
        end else begin
            r_sample_index <= n_sample_index;
            r_fwd_col      <= n_fwd_col;
            r_fwd_row      <= n_fwd_row;
            r_mir_col      <= n_mir_col;
            r_mir_row      <= n_mir_row;
            r_fwd_done     <= n_fwd_done;
            r_mir_done     <= n_mir_done;
            r_past_end     <= n_past_end;
        end
    end

    icfd_out_buf #(
        .DATA_W (DW)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res_data),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (buf_data),
        .i_stall (i_stall)
    );

    assign o_pixel_x     = buf_data[DW-1 -: PXW];
    assign o_pixel_y     = buf_data[VALUE_W +: PYW];
    assign o_pixel_value = buf_data[VALUE_W-1:0];

`ifndef ASSERT_OFF
    a_past_end_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_past_end && !i_first_sample) |-> !res_valid)
        else $error("result produced after field end");

    a_restart_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_first_sample) |=> (r_sample_index == SW'(1)))
        else $error("sample index not restarted");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd_col <= NXW'(MAX_NX)) && (r_mir_col <= NXW'(MAX_NX)))
        else $error("tile column beyond maximum");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: interlaced_ccd_field_demux regression
// The test feeds CCD field samples through a queue-driven sender and checks
// every pixel position the block puts out. The expected positions come from
// a behavioral predictor that is updated whenever a sample or a register
// write is accepted. The test runs directed fields first. It then runs random
// phases with clean, spliced and noisy fields and with several register
// settings and idle patterns. One phase holds the receiver off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb;
    import icfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PIX_W         = 12;
    localparam int unsigned FIELD_SAMPLES = DEF_MAX_WIDTH * DEF_MAX_HEIGHT / 2;
    localparam int          SETTLE        = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 900;
    localparam int          MAX_BLOCKS    = 8;
    localparam int          TIMEOUT_NS    = 2_000_000;

    typedef struct packed {
        logic               field_sel;
        logic               restart;
        logic [VALUE_W-1:0] value;
    } t_sample;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [VALUE_W-1:0] value;
    } t_pixel;

    typedef enum {FIELD_CLEAN, FIELD_SPLICED, FIELD_NOISE} t_field_kind;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic                  i_field_select = 1'b0;
    logic                  i_first_sample = 1'b0;
    logic [VALUE_W-1:0]    i_sample_value = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [PIX_W-1:0]      o_pixel_x;
    logic [PIX_W-1:0]      o_pixel_y;
    logic [VALUE_W-1:0]    o_pixel_value;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    interlaced_ccd_field_demux i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_field_select (i_field_select),
        .i_first_sample (i_first_sample),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_value  (o_pixel_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_sample pending_samples[$];
    t_pixel  expected_pixels[$];
    int      error_count   = 0;
    bit      sample_taken  = 1'b0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    bit      hold_go       = 1'b0;
    bit      receiver_hold = 1'b0;

    // register shadow
    bit                 shadow_binned = 1'b0;
    bit [7:0]           shadow_offset = '0;
    bit [DIM_W-1:0]     shadow_width  = DIM_RESET;
    bit [DIM_W-1:0]     shadow_height = DIM_RESET;
    logic signed [3:0]  shadow_gdx    = '0;
    logic signed [3:0]  shadow_gdy    = '0;
    logic signed [3:0]  shadow_rdx    = '0;
    logic signed [3:0]  shadow_rdy    = '0;

    // position generator state
    int unsigned next_sample   = 0;
    int unsigned fwd_col       = 0;
    int unsigned fwd_row       = 0;
    int unsigned mir_col       = 0;
    int unsigned mir_row       = 0;
    bit          fwd_exhausted = 1'b0;
    bit          mir_exhausted = 1'b0;
    bit          field_overrun = 1'b0;

    task automatic flag_error(input string msg);
        if (error_count < 100) $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit map_sample(input bit fsel, input bit restart,
                                      input logic [VALUE_W-1:0] value, output t_pixel px);
        int unsigned s, w, h, nx, ny, o2, bf, bm, k, j, col, row;
        bit fwd, exhausted;
        int sx, sy, x, y;
        px = '0;
        if (restart) begin
            s = 0;
            field_overrun = 1'b0;
            fwd_col = 0; fwd_row = 0; mir_col = 0; mir_row = 0;
            fwd_exhausted = 1'b0; mir_exhausted = 1'b0;
        end else begin
            if (field_overrun) return 1'b0;
            s = next_sample;
        end
        if (s + 1 >= FIELD_SAMPLES) field_overrun = 1'b1;
        else next_sample = s + 1;

        w  = (shadow_width  > DEF_MAX_WIDTH)  ? DEF_MAX_WIDTH  : shadow_width;
        h  = (shadow_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : shadow_height;
        nx = (w + 3) / 4;
        ny = (h + 3) / 4;
        o2 = 2 * shadow_offset;
        bm = o2 + 1;
        bf = shadow_binned ? o2 : o2 + 2;

        if (s >= bf && ((s - bf) & 1) == 0) begin
            fwd = 1'b1;
            k = ((s - bf) >> 1) & 3;
            col = fwd_col; row = fwd_row; exhausted = fwd_exhausted;
        end else if (s >= bm && ((s - bm) & 1) == 0) begin
            fwd = 1'b0;
            k = ((s - bm) >> 1) & 3;
            col = mir_col; row = mir_row; exhausted = mir_exhausted;
        end else begin
            return 1'b0;
        end

        if (exhausted || nx == 0 || ny == 0 || col >= nx) begin
            if (fwd) fwd_exhausted = 1'b1;
            else mir_exhausted = 1'b1;
            return 1'b0;
        end

        if (shadow_binned) begin
            if (fwd) begin
                if (fsel) begin sx = 2 + shadow_gdx; sy = 1 + shadow_gdy; end
                else begin sx = 1; sy = 0; end
            end else begin
                if (fsel) begin sx = shadow_rdx - 2; sy = shadow_rdy; end
                else begin sx = -1; sy = 1; end
            end
        end else begin
            if (fwd) begin
                if (fsel) begin sx = 1; sy = 0; end
                else begin sx = 2; sy = -1; end
            end else begin
                if (fsel) begin sx = 0; sy = 0; end
                else begin sx = 1; sy = 1; end
            end
        end

        j = (shadow_binned && fwd) ? (k ^ 1) : k;
        x = int'(4 * col + 2 * (j & 1)) + sx;
        y = int'(4 * row + 2 * (j >> 1)) + sy;
        if (!fwd) x = int'(w) - x;

        if (k == 3) begin
            row++;
            if (row >= ny) begin
                row = 0;
                col++;
                if (col >= nx) exhausted = 1'b1;
            end
        end
        if (fwd) begin
            fwd_col = col; fwd_row = row; fwd_exhausted = exhausted;
        end else begin
            mir_col = col; mir_row = row; mir_exhausted = exhausted;
        end

        if (x < 0 || x >= int'(w) || y < 0 || y >= int'(h)) return 1'b0;
        px.x     = x[PIX_W-1:0];
        px.y     = y[PIX_W-1:0];
        px.value = value;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pixel want;
        bit     hit;
        sample_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BINNED_MODE:   shadow_binned = i_cfg_data[0];
                CFG_SAMPLE_OFFSET: shadow_offset = i_cfg_data[7:0];
                CFG_IMAGE_WIDTH:   shadow_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT:  shadow_height = i_cfg_data;
                CFG_GREEN_DX:      shadow_gdx    = i_cfg_data[3:0];
                CFG_GREEN_DY:      shadow_gdy    = i_cfg_data[3:0];
                CFG_RED_DX:        shadow_rdx    = i_cfg_data[3:0];
                CFG_RED_DY:        shadow_rdy    = i_cfg_data[3:0];
                default: ;
            endcase
        end
        if (sample_taken) begin
            hit = map_sample(i_field_select, i_first_sample, i_sample_value, want);
            if (hit) expected_pixels.push_back(want);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                flag_error($sformatf("unexpected pixel x=%0d y=%0d value=%h",
                                     o_pixel_x, o_pixel_y, o_pixel_value));
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x != want.x)
                    flag_error($sformatf("pixel_x %0d, expected %0d", o_pixel_x, want.x));
                if (o_pixel_y != want.y)
                    flag_error($sformatf("pixel_y %0d, expected %0d", o_pixel_y, want.y));
                if (o_pixel_value != want.value)
                    flag_error($sformatf("pixel_value %h, expected %h",
                                         o_pixel_value, want.value));
            end
        end
    end

    always @(negedge i_clk) begin : sample_driver
        t_sample nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || sample_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_samples.pop_front();
                i_valid        <= 1'b1;
                i_field_select <= nxt.field_sel;
                i_first_sample <= nxt.restart;
                i_sample_value <= nxt.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= receiver_hold || ($urandom_range(99) < stall_pct);
    end

    initial begin : receiver_holdoff
        wait (hold_go);
        receiver_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        receiver_hold = 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("interlaced_ccd_field_demux regression: fail");
        $finish;
    end

    task automatic push_sample(input bit fsel, input bit restart, input logic [15:0] value);
        t_sample item;
        item.field_sel = fsel;
        item.restart   = restart;
        item.value     = value;
        pending_samples.push_back(item);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || i_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input bit binned, input int unsigned off,
                                input int unsigned w, input int unsigned h,
                                input logic [3:0] gdx, input logic [3:0] gdy,
                                input logic [3:0] rdx, input logic [3:0] rdy);
        write_reg(CFG_BINNED_MODE,   CFG_DATA_W'(binned));
        write_reg(CFG_SAMPLE_OFFSET, CFG_DATA_W'(off));
        write_reg(CFG_IMAGE_WIDTH,   CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT,  CFG_DATA_W'(h));
        write_reg(CFG_GREEN_DX,      CFG_DATA_W'(gdx));
        write_reg(CFG_GREEN_DY,      CFG_DATA_W'(gdy));
        write_reg(CFG_RED_DX,        CFG_DATA_W'(rdx));
        write_reg(CFG_RED_DY,        CFG_DATA_W'(rdy));
    endtask

    initial begin : stimulus
        int unsigned phase, counted, off, w, h, cw, ch, blocks, len, flip_at, nfields;
        bit          fs, binned;
        t_field_kind kind;

        counted = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout: unbinned, full-size image; mirrored column hits the right edge
        push_sample(1'b0, 1'b1, 16'h0000);
        push_sample(1'b0, 1'b0, 16'hFFFF);
        push_sample(1'b0, 1'b0, 16'hA5A5);
        push_sample(1'b1, 1'b0, 16'h5A5A);
        push_sample(1'b1, 1'b0, 16'hFFFF);
        push_sample(1'b0, 1'b0, 16'h0001);
        push_sample(1'b1, 1'b1, 16'h8000);
        push_sample(1'b1, 1'b0, 16'h7FFF);
        push_sample(1'b1, 1'b0, 16'h0000);
        push_sample(1'b1, 1'b0, 16'hFFFF);
        wait_idle();

        // binned, one 4x4 tile, extreme shifts, field change without restart
        program_regs(1'b1, 1, 4, 4, 4'h8, 4'h7, 4'h7, 4'h8);
        push_sample(1'b1, 1'b1, 16'hFFFF);
        for (int i = 1; i < 14; i++)
            push_sample(i >= 7 ? 1'b0 : 1'b1, 1'b0, 16'($urandom()));
        wait_idle();

        phase = 0;
        while (counted < RANDOM_ITEMS || phase < 6) begin
            phase++;
            binned = 1'($urandom_range(0, 1));
            off    = $urandom_range(0, 6);
            w      = $urandom_range(1, 24);
            h      = $urandom_range(1, 24);
            case (phase)
                1: begin off = 255; w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
                2: begin w = 8191; h = 8191; end
                3: begin off = 0; w = 16; h = 16; end
                4: w = 0;
                5: begin w = 4096; h = 0; end
                6: begin w = 4096; h = 4096; end
                default: if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 8191);
            endcase
            program_regs(binned, off, w, h, 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)));

            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            if (phase == 3) begin
                send_idle_pct = 0;
                stall_pct     = 0;
                hold_go       = 1'b1;
            end

            cw     = (w > DEF_MAX_WIDTH)  ? DEF_MAX_WIDTH  : w;
            ch     = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
            blocks = ((cw + 3) / 4) * ((ch + 3) / 4);
            if (blocks == 0) blocks = 4;
            if (blocks > MAX_BLOCKS) blocks = MAX_BLOCKS;
            nfields = $urandom_range(1, 2);
            if (phase == 1) nfields = 1;
            for (int f = 0; f < nfields; f++) begin
                len     = 2 * off + 8 * blocks + $urandom_range(0, 10);
                fs      = 1'($urandom_range(0, 1));
                flip_at = $urandom_range(0, len);
                case ($urandom_range(0, 19))
                    0, 1, 2: kind = FIELD_SPLICED;
                    3, 4, 5: kind = FIELD_NOISE;
                    default: kind = FIELD_CLEAN;
                endcase
                if (phase == 3) kind = FIELD_CLEAN;
                for (int i = 0; i < len; i++) begin
                    case (kind)
                        FIELD_CLEAN:
                            push_sample(fs, i == 0, 16'($urandom()));
                        FIELD_SPLICED:
                            push_sample(i >= flip_at ? !fs : fs, 1'b0, 16'($urandom()));
                        default:
                            push_sample(1'($urandom_range(0, 1)),
                                        $urandom_range(0, 19) == 0, 16'($urandom()));
                    endcase
                end
                counted += len;
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("interlaced_ccd_field_demux regression: pass");
        end else begin
            $display("interlaced_ccd_field_demux regression: fail");
        end
        $finish;
    end

endmodule
